>>> design/assert_macros.svh
// Assertion macros for the stack-with-search design; lsws_ctrl is the file that uses them.
// Depends on nothing; the files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSWS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSWS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSWS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> design/lsws_pkg.sv
// Shared constants, codes and payload types for the stack-with-search block.
// Depends on nothing.
package lsws_pkg;

	localparam int DEPTH     = 64;
	localparam int WORD_BITS = 32;
	localparam int ADDR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int CAP_BITS  = 7;
	localparam int CMP_BITS  = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;

	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(64);

	localparam logic [1:0] KIND_PUSH   = 2'd0;
	localparam logic [1:0] KIND_POP    = 2'd1;
	localparam logic [1:0] KIND_SEARCH = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_MISS  = 2'd3;

	typedef struct packed {
		logic [1:0]           kind;
		logic [WORD_BITS-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [WORD_BITS-1:0] popped_value;
		logic [CNT_BITS-1:0]  distance;
		logic [WORD_BITS-1:0] top_value;
		logic                 is_empty;
		logic [CNT_BITS-1:0]  count;
	} out_item_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_BITS-1:0] waddr;
		logic [WORD_BITS-1:0] wdata;
		logic                 re;
		logic [ADDR_BITS-1:0] raddr;
	} mem_req_t;

endpackage

>>> design/lsws_store.sv
// Stack word memory: one write port, one read port, registered read data.
// Depends on lsws_pkg.
module lsws_store
	import lsws_pkg::*;
(
	input  logic                 clk,
	input  mem_req_t             req,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/lsws_ctrl.sv
// Stack sequencer: entry count, cached top word, pop refill and search walk.
// Depends on lsws_pkg and assert_macros.svh; its mem_req port is wired to lsws_store in the top level.
`include "assert_macros.svh"
module lsws_ctrl
	import lsws_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	input  logic [CAP_BITS-1:0]  capacity,
	output logic                 res_valid,
	output out_item_t            res_item,
	input  logic                 res_ready,
	output mem_req_t             mem_req,
	input  logic [WORD_BITS-1:0] mem_rdata
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_POPRD = 2'd1;
	localparam logic [1:0] S_SRCH  = 2'd2;

	logic [1:0]           state_q, state_n;
	logic [CNT_BITS-1:0]  cnt_q, cnt_n;
	logic [WORD_BITS-1:0] top_q, top_n;
	logic [WORD_BITS-1:0] hold_q, hold_n;
	logic [ADDR_BITS-1:0] idx_q, idx_n;
	logic [CNT_BITS-1:0]  dist_q, dist_n;

	logic                 accept;
	logic                 push_ok;
	logic [CMP_BITS-1:0]  cap_ext, depth_ext, eff_cap, cnt_ext;
	logic [CNT_BITS-1:0]  cnt_m2;
	logic                 hit;

	assign in_stall  = (state_q != S_IDLE) || !res_ready;
	assign accept    = in_valid && !in_stall;
	assign cap_ext   = CMP_BITS'(capacity);
	assign depth_ext = CMP_BITS'(DEPTH);
	assign eff_cap   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
	assign cnt_ext   = CMP_BITS'(cnt_q);
	assign push_ok   = cnt_ext < eff_cap;
	assign cnt_m2    = cnt_q - CNT_BITS'(2);
	assign hit       = (mem_rdata == hold_q);

	always_comb begin
		state_n   = state_q;
		cnt_n     = cnt_q;
		top_n     = top_q;
		hold_n    = hold_q;
		idx_n     = idx_q;
		dist_n    = dist_q;
		res_valid = 1'b0;
		mem_req   = '0;
		res_item  = '0;
		res_item.status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_valid = 1'b1;
					unique case (in_item.kind)
						KIND_PUSH: begin
							if (push_ok) begin
								mem_req.we    = 1'b1;
								mem_req.waddr = cnt_q[ADDR_BITS-1:0];
								mem_req.wdata = in_item.value;
								cnt_n         = cnt_q + CNT_BITS'(1);
								top_n         = in_item.value;
							end else begin
								res_item.status = ST_FULL;
							end
						end
						KIND_POP: begin
							if (cnt_q == '0) begin
								res_item.status = ST_EMPTY;
							end else if (cnt_q == CNT_BITS'(1)) begin
								res_item.popped_value = top_q;
								cnt_n                 = '0;
							end else begin
								res_valid     = 1'b0;
								mem_req.re    = 1'b1;
								mem_req.raddr = cnt_m2[ADDR_BITS-1:0];
								hold_n        = top_q;
								cnt_n         = cnt_q - CNT_BITS'(1);
								state_n       = S_POPRD;
							end
						end
						KIND_SEARCH: begin
							if (cnt_q == '0) begin
								res_item.status = ST_MISS;
							end else if (top_q == in_item.value) begin
								res_item.distance = CNT_BITS'(1);
							end else if (cnt_q == CNT_BITS'(1)) begin
								res_item.status = ST_MISS;
							end else begin
								res_valid     = 1'b0;
								mem_req.re    = 1'b1;
								mem_req.raddr = cnt_m2[ADDR_BITS-1:0];
								idx_n         = cnt_m2[ADDR_BITS-1:0];
								dist_n        = CNT_BITS'(2);
								hold_n        = in_item.value;
								state_n       = S_SRCH;
							end
						end
						KIND_CLEAR: begin
							cnt_n = '0;
						end
						default: begin
							cnt_n = cnt_q;
						end
					endcase
				end
			end
			S_POPRD: begin
				if (res_ready) begin
					res_valid             = 1'b1;
					res_item.popped_value = hold_q;
					top_n                 = mem_rdata;
					state_n               = S_IDLE;
				end
			end
			S_SRCH: begin
				if (hit || idx_q == '0) begin
					if (res_ready) begin
						res_valid         = 1'b1;
						res_item.status   = hit ? ST_OK : ST_MISS;
						res_item.distance = hit ? dist_q : '0;
						state_n           = S_IDLE;
					end
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = idx_q - ADDR_BITS'(1);
					idx_n         = idx_q - ADDR_BITS'(1);
					dist_n        = dist_q + CNT_BITS'(1);
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
		res_item.count     = cnt_n;
		res_item.is_empty  = (cnt_n == '0);
		res_item.top_value = (cnt_n == '0) ? '0 : top_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		top_q  <= top_n;
		hold_q <= hold_n;
		idx_q  <= idx_n;
		dist_q <= dist_n;
	end

	`LSWS_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_BITS'(DEPTH), "entry count above depth")
	`LSWS_ASSERT(a_wr_idle, clk, arst_n, mem_req.we |-> (state_q == S_IDLE && accept), "write outside an accepted push")
	`LSWS_ASSERT(a_srch_addr, clk, arst_n, (state_q == S_SRCH && mem_req.re) |-> (CNT_BITS'(mem_req.raddr) < cnt_q), "search read beyond stack top")
	`LSWS_ASSERT(a_poprd_done, clk, arst_n, (state_q == S_POPRD && res_ready) |=> (state_q == S_IDLE), "pop refill did not finish")
	`LSWS_ASSERT(a_res_ready, clk, arst_n, res_valid |-> res_ready, "result issued while output register full")

endmodule

>>> design/lifo_stack_with_search_core.sv
// Top level of the bounded stack with search: capacity register, output register, wiring.
// Depends on lsws_pkg, lsws_store and lsws_ctrl.
// One operation per transfer: push, clear, pop of the last entry, a search on an empty or
// one-entry stack and a search matching the top word give their result in the cycle they
// are taken; a pop that leaves entries first reads the new top word back from the stack
// memory; any other search walks the entries below the top one at a time through the
// single read port of the stack memory. A new item is taken once the previous result has
// entered the output register and that register is free or being emptied. No clearing pass
// follows reset. The user must write capacity only while the block is idle; the block
// itself does not enforce it. Values above 64 act as 64, zero rejects every push.
module lifo_stack_with_search_core
	import lsws_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CAP_BITS-1:0] cfg_data
);

	logic [CAP_BITS-1:0]  capacity_q;
	logic                 out_valid_q;
	out_item_t            out_item_q;
	logic                 res_valid;
	logic                 res_ready;
	out_item_t            res_item;
	mem_req_t             mem_req;
	logic [WORD_BITS-1:0] mem_rdata;

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_item_q <= res_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	lsws_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	lsws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.capacity  (capacity_q),
		.res_valid (res_valid),
		.res_item  (res_item),
		.res_ready (res_ready),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

endmodule

>>> tb/lifo_stack_with_search_core_test.sv
// Self-checking testbench for lifo_stack_with_search_core: directed and random push, pop,
// search and clear traffic under several capacities, with random gaps and output stalls.
// Depends on lsws_pkg and the lifo_stack_with_search_core RTL.
module lifo_stack_with_search_core_test;
	import lsws_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int PHASES     = 10;
	localparam int PHASE_LEN  = 95;

	class stack_shadow;
		logic [WORD_BITS-1:0] words [DEPTH];
		int                   depth_now;
		int                   cap;
		out_item_t            due_results [$];
		int unsigned          mismatches;
		int unsigned          results_seen;
		int unsigned          search_hits;
		int unsigned          full_rejects;
		int unsigned          empty_pops;
		int                   deepest;

		function new();
			depth_now    = 0;
			cap          = int'(CAP_RESET);
			mismatches   = 0;
			results_seen = 0;
			search_hits  = 0;
			full_rejects = 0;
			empty_pops   = 0;
			deepest      = 0;
		endfunction

		function void set_capacity(logic [CAP_BITS-1:0] v);
			cap = int'(v);
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void note_transfer(in_item_t it);
			out_item_t r;
			int        limit;
			int        i;
			bit        found;
			r        = '0;
			r.status = ST_OK;
			limit    = (cap > DEPTH) ? DEPTH : cap;
			case (it.kind)
				KIND_PUSH: begin
					if (depth_now < limit) begin
						words[depth_now] = it.value;
						depth_now++;
					end else begin
						r.status = ST_FULL;
						full_rejects++;
					end
				end
				KIND_POP: begin
					if (depth_now == 0) begin
						r.status = ST_EMPTY;
						empty_pops++;
					end else begin
						depth_now--;
						r.popped_value = words[depth_now];
					end
				end
				KIND_SEARCH: begin
					r.status = ST_MISS;
					found    = 1'b0;
					for (i = depth_now - 1; i >= 0 && !found; i--) begin
						if (words[i] == it.value) begin
							found      = 1'b1;
							r.distance = CNT_BITS'(depth_now - i);
							r.status   = ST_OK;
							search_hits++;
						end
					end
				end
				KIND_CLEAR: depth_now = 0;
			endcase
			r.top_value = (depth_now != 0) ? words[depth_now-1] : '0;
			r.is_empty  = (depth_now == 0);
			r.count     = CNT_BITS'(depth_now);
			if (depth_now > deepest)
				deepest = depth_now;
			due_results.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			results_seen++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d: st=%0d pop=%h dist=%0d top=%h empty=%0b cnt=%0d",
						results_seen, got.status, got.popped_value, got.distance,
						got.top_value, got.is_empty, got.count);
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status || got.popped_value !== want.popped_value ||
			    got.distance !== want.distance || got.top_value !== want.top_value ||
			    got.is_empty !== want.is_empty || got.count !== want.count) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d expected st=%0d pop=%h dist=%0d top=%h empty=%0b cnt=%0d",
						results_seen, want.status, want.popped_value, want.distance,
						want.top_value, want.is_empty, want.count);
					$display("result %0d got      st=%0d pop=%h dist=%0d top=%h empty=%0b cnt=%0d",
						results_seen, got.status, got.popped_value, got.distance,
						got.top_value, got.is_empty, got.count);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_item;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_item;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CAP_BITS-1:0] cfg_data;

	stack_shadow          sb;
	bit                   gaps_on;
	bit                   stall_on;
	int                   idle_cycles;
	int unsigned          items_sent;
	int unsigned          cap_writes;
	logic [WORD_BITS-1:0] word_pool [8];

	int phase_push  [PHASES] = '{75, 35, 50, 50, 40, 45, 55, 70, 30, 50};
	int phase_pop   [PHASES] = '{ 8, 30, 20, 25, 20, 25, 20, 10, 35, 20};
	int phase_clear [PHASES] = '{ 0,  2,  3,  3,  0,  3,  2,  0,  3,  3};

	lifo_stack_with_search_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// output side back-pressure: bursts of free and stalled cycles
	initial begin
		int left;
		bit hold;
		left      = 0;
		hold      = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				if (!stall_on) begin
					hold = 1'b0;
					left = 1;
				end else if ($urandom_range(0, 99) < 65) begin
					hold = 1'b0;
					left = $urandom_range(1, 6);
				end else begin
					hold = 1'b1;
					left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					                                   : $urandom_range(1, 3);
				end
			end
			left--;
			out_stall <= hold;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_item);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_op(input logic [1:0] kind, input logic [WORD_BITS-1:0] value);
		in_item_t it;
		it.kind  = kind;
		it.value = value;
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		sb.note_transfer(it);
		items_sent++;
	endtask

	task automatic hold_input(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// wait until every expected result is back, then a short quiet spell
	task automatic settle();
		hold_input(1);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_BITS-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_capacity(v);
		cap_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [WORD_BITS-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return word_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic logic [WORD_BITS-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (sb.depth_now > 0 && r < 60)
			return sb.words[$urandom_range(0, sb.depth_now - 1)];
		return pick_word();
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic run_phase(input int p);
		int                   n;
		int                   r;
		logic [WORD_BITS-1:0] w;
		for (n = 0; n < PHASE_LEN; n++) begin
			hold_input(pick_gap());
			r = $urandom_range(0, 99);
			if (r < phase_push[p])
				send_op(KIND_PUSH, pick_word());
			else if (r < phase_push[p] + phase_pop[p])
				send_op(KIND_POP, $urandom);
			else if (r < phase_push[p] + phase_pop[p] + phase_clear[p])
				send_op(KIND_CLEAR, $urandom);
			else begin
				w = pick_key();
				send_op(KIND_SEARCH, w);
			end
		end
	endtask

	initial begin
		int                  p;
		logic [CAP_BITS-1:0] cap_plan [PHASES];
		sb          = new();
		idle_cycles = 0;
		items_sent  = 0;
		cap_writes  = 0;
		gaps_on     = 1'b0;
		stall_on    = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_item     = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		word_pool[0] = '0;
		word_pool[1] = '1;
		word_pool[2] = 32'h8000_0000;
		word_pool[3] = 32'h0000_0001;
		for (p = 4; p < 8; p++)
			word_pool[p] = $urandom;
		cap_plan = '{7'd127, 7'd64, 7'd5, 7'd1, 7'd0, 7'd2,
		             CAP_BITS'($urandom_range(1, 64)), CAP_BITS'($urandom_range(65, 127)),
		             7'd64, 7'd33};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: small capacity, extremes, duplicates, empty cases
		write_capacity(7'd3);
		send_op(KIND_SEARCH, '0);
		send_op(KIND_POP, '1);
		send_op(KIND_PUSH, '0);
		send_op(KIND_PUSH, '1);
		send_op(KIND_PUSH, '0);
		send_op(KIND_PUSH, 32'h1234_5678);
		send_op(KIND_SEARCH, '0);
		send_op(KIND_SEARCH, '1);
		send_op(KIND_SEARCH, 32'h1234_5678);
		send_op(KIND_POP, '0);
		send_op(KIND_SEARCH, '0);
		send_op(KIND_CLEAR, '1);
		send_op(KIND_SEARCH, '1);
		send_op(KIND_POP, '0);
		send_op(KIND_PUSH, 32'hA5A5_A5A5);
		send_op(KIND_PUSH, 32'h5A5A_5A5A);
		settle();
		// capacity dropped below the current count
		write_capacity(7'd1);
		send_op(KIND_PUSH, 32'hDEAD_BEEF);
		send_op(KIND_POP, '0);
		send_op(KIND_PUSH, 32'hDEAD_BEEF);
		send_op(KIND_POP, '0);
		send_op(KIND_PUSH, 32'h8000_0001);
		settle();
		write_capacity(7'd0);
		send_op(KIND_PUSH, 32'h7FFF_FFFF);
		send_op(KIND_SEARCH, 32'h8000_0001);
		send_op(KIND_POP, '0);
		send_op(KIND_PUSH, 32'h7FFF_FFFF);
		settle();

		for (p = 0; p < PHASES; p++) begin
			write_capacity(cap_plan[p]);
			gaps_on  = (p != 0) && ($urandom_range(0, 3) != 0);
			stall_on = (p != 0) && ($urandom_range(0, 3) != 0);
			run_phase(p);
			settle();
		end

		stall_on = 1'b1;
		settle();
		repeat (80) @(posedge clk);
		$display("Ran %0d items and %0d results over %0d capacity settings, stack depth up to %0d",
			items_sent, sb.results_seen, cap_writes, sb.deepest);
		$display("Search hits %0d, rejected pushes %0d, pops on empty %0d",
			sb.search_hits, sb.full_rejects, sb.empty_pops);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
